[hw/rtl/gsm_pkg.sv]
// shared widths and fixed-point constants of the graph segment merger
`default_nettype none
package gsm_pkg;
   // field widths
   localparam int PIX_IN_W = 16;
   localparam int WEIGHT_W = 17;
   localparam int SIZE_W   = 17;
   localparam int THR_W    = 24;
   localparam int K_W      = 16;
   localparam int FRAC_W   = 7;
   localparam int DVD_W    = K_W + FRAC_W;

   // packed stream widths
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 40;

   localparam logic [K_W-1:0]    K_RESET  = 16'd100;
   localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
   localparam logic [THR_W-1:0]  THR_MAX  = '1;

   // status seen by the top level
   typedef struct packed {
      logic clearing;
   } back_status_type;
endpackage
`default_nettype wire

[hw/rtl/gsm_queue.sv]
// two-entry queue between the front and back parts
`default_nettype none
module gsm_queue #(
   parameter int W = 50
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_valid,
   output logic             push_ready,
   input  wire logic [W-1:0] push_data,
   output logic             pop_valid,
   input  wire logic         pop_ready,
   output logic [W-1:0]     pop_data
);
   logic [W-1:0] mem_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff;
   logic         do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= ~rd_ptr_ff;
         if (do_push && !do_pop) count_ff <= count_ff + 2'd1;
         else if (do_pop && !do_push) count_ff <= count_ff - 2'd1;
      end
   end
endmodule
`default_nettype wire

[hw/rtl/gsm_front.sv]
// front part: accepts edges and reduces pixel indices into the forest range
`default_nettype none
module gsm_front #(
   parameter int PIXELS = 65536,
   parameter int PW     = 16,
   parameter int QW     = 50
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [gsm_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire logic                                req_tlast,
   output logic                                     q_valid,
   input  wire logic                                q_ready,
   output logic [QW-1:0]                            q_data
);
   import gsm_pkg::*;

   localparam bit NEED_MOD = (PIXELS < (1 << PIX_IN_W));
   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_MOD  = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;
   localparam logic [PW:0] PIX_C = (PW+1)'(PIXELS);
   localparam logic [31:0] PIX_32 = 32'(PIXELS);
   // floor(2^32 / PIXELS): quotient estimate is low by at most one
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(PIXELS));

   logic [1:0]            state_ff, state_in;
   logic [PIX_IN_W-1:0]   a_src_ff, b_src_ff;
   logic [PIX_IN_W-1:0]   a_q_ff, b_q_ff;
   logic [PW:0]           a_rem_ff, b_rem_ff;
   logic [PW-1:0]         a_idx_ff, b_idx_ff;
   logic [WEIGHT_W-1:0]   w_ff;
   logic                  last_ff;
   logic [1:0]            step_ff;
   logic [47:0]           a_prod, b_prod;
   logic [31:0]           a_diff, b_diff;
   logic [PW-1:0]         a_fix, b_fix;
   logic                  accept;

   assign req_tready = (state_ff == F_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign q_valid    = (state_ff == F_PUSH);
   assign q_data     = {last_ff, w_ff, b_idx_ff, a_idx_ff};

   // remainder by reciprocal multiplication: estimate, subtract, one correction
   always_comb begin
      a_prod = 48'(a_src_ff) * 48'(RECIP);
      b_prod = 48'(b_src_ff) * 48'(RECIP);
      a_diff = 32'(a_src_ff) - 32'(a_q_ff) * PIX_32;
      b_diff = 32'(b_src_ff) - 32'(b_q_ff) * PIX_32;
      a_fix  = (a_rem_ff >= PIX_C) ? PW'(a_rem_ff - PIX_C) : PW'(a_rem_ff);
      b_fix  = (b_rem_ff >= PIX_C) ? PW'(b_rem_ff - PIX_C) : PW'(b_rem_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: if (accept) state_in = NEED_MOD ? F_MOD : F_PUSH;
         F_MOD:  if (step_ff == 2'd2) state_in = F_PUSH;
         F_PUSH: if (q_ready) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= F_IDLE;
      else       state_ff <= state_in;
   end

   // item registers
   always_ff @(posedge clock) begin
      if (accept) begin
         a_src_ff <= req_tdata[PIX_IN_W-1:0];
         b_src_ff <= req_tdata[2*PIX_IN_W-1:PIX_IN_W];
         w_ff     <= req_tdata[2*PIX_IN_W+WEIGHT_W-1:2*PIX_IN_W];
         last_ff  <= req_tlast;
         step_ff  <= 2'd0;
         if (!NEED_MOD) begin
            a_idx_ff <= PW'(req_tdata[PIX_IN_W-1:0]);
            b_idx_ff <= PW'(req_tdata[2*PIX_IN_W-1:PIX_IN_W]);
         end
      end else if (state_ff == F_MOD) begin
         if (step_ff == 2'd0) begin
            a_q_ff <= a_prod[47:32];
            b_q_ff <= b_prod[47:32];
         end else if (step_ff == 2'd1) begin
            a_rem_ff <= (PW+1)'(a_diff);
            b_rem_ff <= (PW+1)'(b_diff);
         end else begin
            a_idx_ff <= a_fix;
            b_idx_ff <= b_fix;
         end
         step_ff <= step_ff + 2'd1;
      end
   end
endmodule
`default_nettype wire

[hw/rtl/gsm_div.sv]
// iterative restoring divider for the threshold term k*128 / size
`default_nettype none
module gsm_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [gsm_pkg::DVD_W-1:0]      dividend,
   input  wire logic [gsm_pkg::SIZE_W-1:0]     divisor,
   output logic                                done,
   output logic [gsm_pkg::DVD_W-1:0]           quotient
);
   import gsm_pkg::*;

   logic                busy_ff, done_ff;
   logic [4:0]          cnt_ff;
   logic [DVD_W-1:0]    dvd_ff;
   logic [SIZE_W-1:0]   dvs_ff, rem_ff;
   logic [SIZE_W:0]     rem_sh;
   logic                ge;

   assign done     = done_ff;
   assign quotient = dvd_ff;

   // one quotient bit a step
   always_comb begin
      rem_sh = {rem_ff, dvd_ff[DVD_W-1]};
      ge     = (rem_sh >= {1'b0, dvs_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 5'd0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
         cnt_ff <= 5'(DVD_W - 1);
      end else if (busy_ff) begin
         rem_ff <= ge ? SIZE_W'(rem_sh - {1'b0, dvs_ff}) : SIZE_W'(rem_sh);
         dvd_ff <= {dvd_ff[DVD_W-2:0], ge};
         cnt_ff <= cnt_ff - 5'd1;
      end
   end
endmodule
`default_nettype wire

[hw/rtl/gsm_back.sv]
// back part: union-find forest in memory, root finds, merge and result register
`default_nettype none
module gsm_back #(
   parameter int PIXELS = 65536,
   parameter int PW     = 16,
   parameter int QW     = 50
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              q_valid,
   output logic                                   q_ready,
   input  wire logic [QW-1:0]                     q_data,
   input  wire logic [gsm_pkg::K_W-1:0]           merge_constant,
   output logic                                   div_start,
   output logic [gsm_pkg::DVD_W-1:0]              div_dividend,
   output logic [gsm_pkg::SIZE_W-1:0]             div_divisor,
   input  wire logic                              div_done,
   input  wire logic [gsm_pkg::DVD_W-1:0]         div_quotient,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [gsm_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                   rsp_tlast,
   output gsm_pkg::back_status_type               status
);
   import gsm_pkg::*;

   localparam logic [3:0] S_CLR    = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_FA_RD  = 4'd2;
   localparam logic [3:0] S_FA_CHK = 4'd3;
   localparam logic [3:0] S_FB_RD  = 4'd4;
   localparam logic [3:0] S_FB_CHK = 4'd5;
   localparam logic [3:0] S_SA_RD  = 4'd6;
   localparam logic [3:0] S_SA_CHK = 4'd7;
   localparam logic [3:0] S_SB_RD  = 4'd8;
   localparam logic [3:0] S_SB_CHK = 4'd9;
   localparam logic [3:0] S_DECIDE = 4'd10;
   localparam logic [3:0] S_DIV    = 4'd11;
   localparam logic [3:0] S_WR     = 4'd12;
   localparam logic [3:0] S_OUT    = 4'd13;
   localparam logic [PW-1:0] LAST_IDX = PW'(PIXELS - 1);

   // forest memories
   logic [PW-1:0]     par_mem  [PIXELS];
   logic [SIZE_W-1:0] size_mem [PIXELS];
   logic [THR_W-1:0]  thr_mem  [PIXELS];

   logic [3:0]          state_ff, state_in;
   logic [PW-1:0]       clr_cnt_ff;
   logic [PW-1:0]       b_ff, p_ff, ra_ff, rb_ff, keep_ff, drop_ff, root_ff;
   logic [WEIGHT_W-1:0] w_ff;
   logic                last_ff, merged_ff;
   logic [SIZE_W-1:0]   sa_ff, sb_ff, sum_ff, res_size_ff;
   logic [THR_W-1:0]    ta_ff, tb_ff;
   logic [PW-1:0]       par_rd_ff;
   logic [SIZE_W-1:0]   size_rd_ff;
   logic [THR_W-1:0]    thr_rd_ff;
   logic [PW-1:0]       par_raddr, sz_raddr;
   logic                par_we, sz_we, thr_we;
   logic [PW-1:0]       par_waddr, par_wdata, sz_waddr;
   logic [SIZE_W-1:0]   sz_wdata;
   logic [THR_W-1:0]    thr_sat;
   logic [THR_W:0]      thr_sum;
   logic [DVD_W-1:0]    k_scaled;
   logic [THR_W-1:0]    thr_a, thr_b;
   logic [SIZE_W:0]     size_sum;
   logic [SIZE_W-1:0]   sum_sat;
   logic                do_merge, b_bigger, out_free;
   logic                rsp_valid_ff, rsp_merged_ff, rsp_last_ff;
   logic [PIX_IN_W-1:0] rsp_root_ff;
   logic [SIZE_W-1:0]   rsp_size_ff;

   assign status.clearing = (state_ff == S_CLR);
   assign q_ready         = (state_ff == S_IDLE);
   assign out_free        = !rsp_valid_ff || rsp_tready;

   // merge decision
   always_comb begin
      k_scaled = {merge_constant, {FRAC_W{1'b0}}};
      thr_a    = (sa_ff <= SIZE_W'(1)) ? THR_W'(k_scaled) : ta_ff;
      thr_b    = (sb_ff <= SIZE_W'(1)) ? THR_W'(k_scaled) : tb_ff;
      do_merge = (ra_ff != rb_ff) && (THR_W'(w_ff) <= thr_a) && (THR_W'(w_ff) <= thr_b);
      b_bigger = (sb_ff > sa_ff);
      size_sum = {1'b0, sa_ff} + {1'b0, sb_ff};
      sum_sat  = size_sum[SIZE_W] ? SIZE_MAX : size_sum[SIZE_W-1:0];
      thr_sum  = (THR_W+1)'(w_ff) + (THR_W+1)'(div_quotient);
      thr_sat  = thr_sum[THR_W] ? THR_MAX : thr_sum[THR_W-1:0];
   end

   assign div_start    = (state_ff == S_DECIDE) && do_merge;
   assign div_dividend = k_scaled;
   assign div_divisor  = sum_sat;

   // memory addresses and write data
   always_comb begin
      par_raddr = p_ff;
      sz_raddr  = (state_ff == S_SB_RD) ? rb_ff : ra_ff;
      par_we    = (state_ff == S_CLR) || (state_ff == S_WR);
      sz_we     = par_we;
      thr_we    = (state_ff == S_WR);
      par_waddr = (state_ff == S_CLR) ? clr_cnt_ff : drop_ff;
      par_wdata = (state_ff == S_CLR) ? clr_cnt_ff : keep_ff;
      sz_waddr  = (state_ff == S_CLR) ? clr_cnt_ff : keep_ff;
      sz_wdata  = (state_ff == S_CLR) ? SIZE_W'(1) : sum_ff;
   end

   always_ff @(posedge clock) begin
      if (par_we) par_mem[par_waddr] <= par_wdata;
      par_rd_ff <= par_mem[par_raddr];
   end

   always_ff @(posedge clock) begin
      if (sz_we) size_mem[sz_waddr] <= sz_wdata;
      size_rd_ff <= size_mem[sz_raddr];
   end

   always_ff @(posedge clock) begin
      if (thr_we) thr_mem[keep_ff] <= thr_sat;
      thr_rd_ff <= thr_mem[sz_raddr];
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLR:    if (clr_cnt_ff == LAST_IDX) state_in = S_IDLE;
         S_IDLE:   if (q_valid) state_in = S_FA_RD;
         S_FA_RD:  state_in = S_FA_CHK;
         S_FA_CHK: state_in = (par_rd_ff == p_ff) ? S_FB_RD : S_FA_RD;
         S_FB_RD:  state_in = S_FB_CHK;
         S_FB_CHK: state_in = (par_rd_ff == p_ff) ? S_SA_RD : S_FB_RD;
         S_SA_RD:  state_in = S_SA_CHK;
         S_SA_CHK: state_in = S_SB_RD;
         S_SB_RD:  state_in = S_SB_CHK;
         S_SB_CHK: state_in = S_DECIDE;
         S_DECIDE: state_in = do_merge ? S_DIV : S_OUT;
         S_DIV:    if (div_done) state_in = S_WR;
         S_WR:     state_in = S_OUT;
         S_OUT:    if (out_free) state_in = last_ff ? S_CLR : S_IDLE;
         default:  state_in = S_CLR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLR) clr_cnt_ff <= clr_cnt_ff + PW'(1);
         else                   clr_cnt_ff <= '0;
      end
   end

   // per-edge working registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               b_ff    <= q_data[2*PW-1:PW];
               w_ff    <= q_data[2*PW+WEIGHT_W-1:2*PW];
               last_ff <= q_data[QW-1];
               p_ff    <= q_data[PW-1:0];
            end
         end
         S_FA_CHK: begin
            if (par_rd_ff == p_ff) begin
               ra_ff <= p_ff;
               p_ff  <= b_ff;
            end else begin
               p_ff <= par_rd_ff;
            end
         end
         S_FB_CHK: begin
            if (par_rd_ff == p_ff) rb_ff <= p_ff;
            else                   p_ff  <= par_rd_ff;
         end
         S_SA_CHK: begin
            sa_ff <= size_rd_ff;
            ta_ff <= thr_rd_ff;
         end
         S_SB_CHK: begin
            sb_ff <= size_rd_ff;
            tb_ff <= thr_rd_ff;
         end
         S_DECIDE: begin
            merged_ff <= do_merge;
            keep_ff   <= b_bigger ? rb_ff : ra_ff;
            drop_ff   <= b_bigger ? ra_ff : rb_ff;
            sum_ff    <= sum_sat;
            root_ff   <= do_merge ? (b_bigger ? rb_ff : ra_ff) : ra_ff;
            res_size_ff <= do_merge ? sum_sat : sa_ff;
         end
         default: begin
         end
      endcase
   end

   // result register, frees the sequencer while the item waits
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && out_free) begin
         rsp_merged_ff <= merged_ff;
         rsp_root_ff   <= PIX_IN_W'(root_ff);
         rsp_size_ff   <= res_size_ff;
         rsp_last_ff   <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_size_ff, rsp_root_ff, rsp_merged_ff});
endmodule
`default_nettype wire

[hw/rtl/graph_segment_merger.sv]
// Graph segment merger top level: union-find merge of sorted pixel-graph edges.
// Time from edge accepted to result valid grows with the parent hops of both pixels,
// and a merge adds a pass through the 23-step threshold divider.
// Front index reduction (estimate, subtract, correct) is used only when PIXELS < 65536.
// The back part takes one edge at a time, the next only after the last result is registered.
// Reset (synchronous) and every last edge start a forest clearing pass over all PIXELS entries.
`default_nettype none
module graph_segment_merger #(
   parameter int PIXELS = 65536
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // first_pixel [15:0], second_pixel [31:16], edge_weight [48:32], zero fill
   input  wire logic [gsm_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                               req_tlast,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // merged [0], root_after [16:1], size_after [33:17], zero fill
   output logic [gsm_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic                                    rsp_tlast,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [gsm_pkg::K_W-1:0]            csr_data
);
   import gsm_pkg::*;

   localparam int PW = $clog2(PIXELS);
   localparam int QW = 2*PW + WEIGHT_W + 1;

   logic                 q_in_valid, q_in_ready, q_out_valid, q_out_ready;
   logic [QW-1:0]        q_in_data, q_out_data;
   logic [K_W-1:0]       merge_constant_ff;
   logic                 div_start, div_done;
   logic [DVD_W-1:0]     div_dividend, div_quotient;
   logic [SIZE_W-1:0]    div_divisor;
   back_status_type      back_status;

   // merge constant register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset)          merge_constant_ff <= K_RESET;
      else if (csr_valid) merge_constant_ff <= csr_data;
   end

   gsm_front #(.PIXELS(PIXELS), .PW(PW), .QW(QW)) u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .q_valid(q_in_valid), .q_ready(q_in_ready), .q_data(q_in_data)
   );

   gsm_queue #(.W(QW)) u_queue (
      .clock, .reset,
      .push_valid(q_in_valid), .push_ready(q_in_ready), .push_data(q_in_data),
      .pop_valid(q_out_valid), .pop_ready(q_out_ready), .pop_data(q_out_data)
   );

   gsm_div u_div (
      .clock, .reset, .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .done(div_done), .quotient(div_quotient)
   );

   gsm_back #(.PIXELS(PIXELS), .PW(PW), .QW(QW)) u_back (
      .clock, .reset,
      .q_valid(q_out_valid), .q_ready(q_out_ready), .q_data(q_out_data),
      .merge_constant(merge_constant_ff),
      .div_start, .div_dividend, .div_divisor, .div_done, .div_quotient,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast,
      .status(back_status)
   );

   // a merged result always covers at least two pixels
   a_merged_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[33:17] >= 17'd2)
      else $error("merged result with size below two");

   // component size is never zero
   a_size_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[33:17] != 17'd0)
      else $error("result with zero size");

   // no new result appears while the forest is being cleared
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      back_status.clearing |=> !$rose(rsp_tvalid))
      else $error("result issued during clearing pass");
endmodule
`default_nettype wire

[tb/graph_segment_merger_tb.sv]
// self-checking testbench for the graph segment merger
`timescale 1ns / 100ps
`default_nettype none
module graph_segment_merger_tb;
   import gsm_pkg::*;

   localparam int NPIX       = 65536;
   localparam int WDOG_LIMIT = 300000;
   localparam int PHASES     = 6;
   localparam int PHASE_LEN  = 180;

   // one expected result item
   typedef struct {
      bit              merged;
      bit [15:0]       root;
      bit [SIZE_W-1:0] size;
      bit              done;
   } merge_result_type;

   // union-find predictor and queue of pending results
   class merge_scoreboard;
      bit [15:0]        parent [NPIX];
      bit [SIZE_W-1:0]  comp_size [NPIX];
      bit [THR_W-1:0]   thresh [NPIX];
      bit [K_W-1:0]     k_reg;
      merge_result_type pending_q [$];
      int               errors;

      function void clear_forest();
         for (int i = 0; i < NPIX; i++) begin
            parent[i]    = 16'(i);
            comp_size[i] = SIZE_W'(1);
            thresh[i]    = '0;
         end
      endfunction

      function void reset_all();
         k_reg = K_RESET;
         clear_forest();
      endfunction

      function bit [15:0] root_of(bit [15:0] p);
         while (parent[p] != p) p = parent[p];
         return p;
      endfunction

      function bit [THR_W-1:0] limit_of(bit [15:0] r);
         if (comp_size[r] <= 1) return THR_W'({k_reg, 7'b0});
         return thresh[r];
      endfunction

      function void set_k(bit [K_W-1:0] v);
         k_reg = v;
      endfunction

      function int pending();
         return pending_q.size();
      endfunction

      // accepted edge: work out the merge and its result
      function void note_edge(bit [15:0] a, bit [15:0] b, bit [WEIGHT_W-1:0] w, bit last);
         bit [15:0]        ra, rb, keep, drop;
         bit [SIZE_W:0]    sum;
         bit [31:0]        thr;
         merge_result_type r;
         ra = root_of(a);
         rb = root_of(b);
         r.merged = 1'b0;
         r.root   = ra;
         if (ra != rb && w <= limit_of(ra) && w <= limit_of(rb)) begin
            keep = ra;
            drop = rb;
            if (comp_size[rb] > comp_size[ra]) begin
               keep = rb;
               drop = ra;
            end
            sum = comp_size[keep] + comp_size[drop];
            if (sum > SIZE_MAX) sum = (SIZE_W+1)'(SIZE_MAX);
            parent[drop]    = keep;
            comp_size[keep] = SIZE_W'(sum);
            thr = 32'(w) + 32'({k_reg, 7'b0} / sum);
            if (thr > THR_MAX) thr = 32'(THR_MAX);
            thresh[keep] = THR_W'(thr);
            r.merged = 1'b1;
            r.root   = keep;
         end
         r.size = comp_size[r.root];
         r.done = last;
         pending_q.insert(pending_q.size(), r);
         if (last) clear_forest();
      endfunction

      // accepted result: compare with the oldest expectation
      function void check_result(bit [RSP_DATA_W-1:0] d, bit tl);
         merge_result_type e;
         if (pending_q.size() == 0) begin
            $error("result item with none expected: tdata %h", d);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         if (d[0] !== e.merged) begin
            $error("merged: expected %0d actual %0d", e.merged, d[0]);
            errors++;
         end
         if (d[16:1] !== e.root) begin
            $error("root_after: expected %0d actual %0d", e.root, d[16:1]);
            errors++;
         end
         if (d[33:17] !== e.size) begin
            $error("size_after: expected %0d actual %0d", e.size, d[33:17]);
            errors++;
         end
         if (tl !== e.done) begin
            $error("done_res: expected %0d actual %0d", e.done, tl);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [K_W-1:0]        csr_data = '0;

   merge_scoreboard sb = new();
   int send_idle  = 0;
   int recv_stall = 0;
   int quiet_cycles = 0;

   graph_segment_merger uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // result side: random stalls, check on handshake, watchdog
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall);
      if (rsp_tvalid && rsp_tready && !reset) sb.check_result(rsp_tdata, rsp_tlast);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // present one edge item and wait for its acceptance
   task send_edge(input bit [15:0] a, input bit [15:0] b, input bit [WEIGHT_W-1:0] w,
                  input bit last);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {7'b0, w, b, a};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_edge(a, b, w, last);
   endtask

   // register write once all results are back and the block has settled
   task write_k(input bit [K_W-1:0] v);
      req_tvalid <= 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_valid <= 1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.set_k(v);
   endtask

   initial begin
      bit [K_W-1:0]      kset [PHASES];
      bit [15:0]         base, a, b;
      int                lim;
      bit [WEIGHT_W-1:0] w;
      sb.reset_all();
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed edges at default k: extremes, ties, self edge, heavy weight
      send_edge(16'd0, 16'd65535, 17'd0, 0);
      send_edge(16'd65535, 16'd0, 17'd5, 0);
      send_edge(16'd5, 16'd5, 17'd0, 0);
      send_edge(16'd1, 16'd2, 17'd131071, 0);
      send_edge(16'd1, 16'd2, 17'd12800, 0);
      send_edge(16'd3, 16'd4, 17'd100, 0);
      send_edge(16'd3, 16'd1, 17'd200, 0);
      send_edge(16'd0, 16'd6, 17'd300, 0);
      send_edge(16'd6, 16'd2, 17'd6000, 0);
      send_edge(16'd4, 16'd65535, 17'd9000, 0);
      send_edge(16'd7, 16'd3, 17'd12801, 0);
      send_edge(16'd7, 16'd8, 17'd65535, 0);
      send_edge(16'd2, 16'd65535, 17'd400, 1);
      send_edge(16'd2, 16'd1, 17'd0, 0);

      kset[0] = 16'd0;
      kset[1] = 16'd65535;
      kset[2] = 16'd100;
      kset[3] = 16'd1;
      kset[4] = 16'($urandom_range(0, 65535));
      kset[5] = 16'($urandom_range(20, 400));

      for (int ph = 0; ph < PHASES; ph++) begin
         write_k(kset[ph]);
         case (ph % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 46; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 46; end
            default: begin send_idle = 25; recv_stall = 25; end
         endcase
         base = 16'($urandom_range(0, NPIX - 64));
         lim  = kset[ph] * 128;
         if (lim > 131071) lim = 131071;
         if (lim < 4) lim = 4;
         for (int i = 0; i < PHASE_LEN; i++) begin
            // mostly edges inside a small window, some noise over the full range
            if ($urandom_range(0, 9) == 0) begin
               a = 16'($urandom);
               b = 16'($urandom);
               w = 17'($urandom);
            end else begin
               a = base + 16'($urandom_range(0, 47));
               b = base + 16'($urandom_range(0, 47));
               w = 17'($urandom_range(0, lim));
            end
            send_edge(a, b, w, i == PHASE_LEN - 1);
         end
      end
      send_idle = 0;
      recv_stall = 0;
      req_tvalid <= 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
`default_nettype wire

[graph_segment_merger.f]
hw/rtl/gsm_pkg.sv
hw/rtl/gsm_queue.sv
hw/rtl/gsm_front.sv
hw/rtl/gsm_div.sv
hw/rtl/gsm_back.sv
hw/rtl/graph_segment_merger.sv
tb/graph_segment_merger_tb.sv
